### rtl/core/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg: shared types and constants of the line follower steering core
// Config record, controller command/status records, fixed sensor weights and
// the wheel speed mapping used by the datapath.
// ----------------------------------------------------------------------------
package lfps_pkg;

	// Sensor array and config layout
	localparam int SENSOR_MAX = 8;
	localparam int CFG_W      = 48;
	localparam int THR_EXT_W  = 64;
	localparam int GAIN_W     = 32;
	localparam int DUTY_W     = 8;
	localparam int ERR_W      = 12;
	localparam int DERIV_W    = 13;
	localparam int SUM_W      = 5;
	localparam int CNT_W      = 4;
	localparam int MAG_W      = 4;

	// Register indexes on the config port
	localparam logic [2:0] REG_THR_LO  = 3'd0;
	localparam logic [2:0] REG_THR_HI  = 3'd1;
	localparam logic [2:0] REG_KP      = 3'd2;
	localparam logic [2:0] REG_KI      = 3'd3;
	localparam logic [2:0] REG_KD      = 3'd4;
	localparam logic [2:0] REG_BASE    = 3'd5;
	localparam logic [2:0] REG_REVERSE = 3'd6;

	// Divider: |sum| * 256 over the active count, two quotient bits a cycle
	localparam int DIVIDEND_W     = 12;
	localparam int DIV_BITS_CYCLE = 2;
	localparam int DIV_STEPS      = DIVIDEND_W / DIV_BITS_CYCLE;
	localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

	// Shared multiplier: 48-bit operand taken in two 24-bit chunks
	localparam int OP_W    = 48;
	localparam int CHUNK_W = 24;
	localparam int PROD_W  = GAIN_W + CHUNK_W + 1;
	localparam int ACC_W   = 84;
	localparam int SPEED_W = ACC_W + 1;

	// PID term select
	localparam logic [1:0] TERM_P = 2'd0;
	localparam logic [1:0] TERM_I = 2'd1;
	localparam logic [1:0] TERM_D = 2'd2;

	// Position weights, leftmost sensor first
	localparam logic signed [3:0] WEIGHTS [SENSOR_MAX] =
		'{-4'sd4, -4'sd3, -4'sd3, 4'sd1, 4'sd1, 4'sd2, 4'sd3, 4'sd4};

	// Speed limits in Q.16
	localparam logic signed [SPEED_W-1:0] SPEED_TOP  = SPEED_W'(256) << 16;
	localparam logic signed [SPEED_W-1:0] SPEED_BACK = -(SPEED_W'(1) << 16);

	typedef struct packed {
		logic [CFG_W-1:0]         thr_lo;
		logic [CFG_W-1:0]         thr_hi;
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
		logic [DUTY_W-1:0]        base;
		logic [DUTY_W-1:0]        rev;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		thr_lo: '0,
		thr_hi: '0,
		kp:     32'sd25600,
		ki:     32'sd0,
		kd:     32'sd25600000,
		base:   8'd240,
		rev:    8'd70
	};

	typedef struct packed {
		logic       load;
		logic       sense;
		logic       div_step;
		logic       err_upd;
		logic       acc_clr;
		logic       mul;
		logic [1:0] term;
		logic       hi;
		logic       acc_add;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic lost;
	} status_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              reverse;
	} wheel_t;

	// Map a Q.16 wheel speed to duty and direction
	function automatic wheel_t wheel_f(input logic signed [SPEED_W-1:0] v,
		input logic [DUTY_W-1:0] rev);
		wheel_t w;
		w.duty    = v[23:16];
		w.reverse = 1'b0;
		if (v >= SPEED_TOP) begin
			w.duty = '1;
		end else if (v <= SPEED_BACK) begin
			w.duty    = rev;
			w.reverse = 1'b1;
		end else if (v < 0) begin
			w.duty = '0;
		end
		return w;
	endfunction

endpackage

### rtl/core/lfps_ctrl.sv
// ----------------------------------------------------------------------------
// lfps_ctrl: sequencer of the steering core
// Walks one item through sense, divide (skipped when the line is lost),
// error update, multiply-accumulate and output load; owns in_stall and out_valid.
// ----------------------------------------------------------------------------
module lfps_ctrl
	import lfps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SENSE = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_ERR   = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_ACC   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]           state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
	logic [1:0]           term_q, term_d;
	logic                 hi_q, hi_d;
	logic                 out_valid_q;
	logic                 out_free;

	// Output slot can take a result this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		div_cnt_d = div_cnt_q;
		term_d    = term_q;
		hi_d      = hi_q;
		cmd       = '0;
		cmd.term  = term_q;
		cmd.hi    = hi_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SENSE;
				end
			end
			S_SENSE: begin
				cmd.sense = 1'b1;
				div_cnt_d = '0;
				state_d   = status.lost ? S_ERR : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d    = div_cnt_q + 1'b1;
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_ERR;
				end
			end
			S_ERR: begin
				cmd.err_upd = 1'b1;
				cmd.acc_clr = 1'b1;
				term_d      = TERM_P;
				hi_d        = 1'b0;
				state_d     = S_MUL;
			end
			S_MUL: begin
				cmd.mul     = 1'b1;
				cmd.acc_add = !(term_q == TERM_P && !hi_q);
				hi_d        = !hi_q;
				if (hi_q) begin
					unique case (term_q)
						TERM_P:  term_d = TERM_I;
						TERM_I:  term_d = TERM_D;
						default: begin
							term_d  = TERM_P;
							state_d = S_ACC;
						end
					endcase
				end
			end
			S_ACC: begin
				cmd.acc_add = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			term_q      <= TERM_P;
			hi_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			div_cnt_q <= div_cnt_d;
			term_q    <= term_d;
			hi_q      <= hi_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A waiting item always moves on to sensing
	a_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q == S_SENSE))
		else $error("accepted item did not start sensing");

	// The divider moves on to the error update after its last step
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) |=> (state_q == S_ERR))
		else $error("divider step count wrong");

	// The last accumulate follows the high derivative chunk
	a_mul_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |-> ($past(state_q) == S_MUL && $past(term_q) == TERM_D
			&& $past(hi_q)))
		else $error("multiply sequence cut short");

	// A held result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && out_stall) |=> (state_q == S_OUT))
		else $error("result loaded over a stalled one");

endmodule

### rtl/core/lfps_dp.sv
// ----------------------------------------------------------------------------
// lfps_dp: datapath of the steering core
// Threshold compare, weighted sum, restoring divider, PID state, shared
// multiplier with accumulator, wheel mapping and the output register.
// ----------------------------------------------------------------------------
module lfps_dp
	import lfps_pkg::*;
#(
	parameter int SENSOR_COUNT   = 8,
	parameter int SAMPLE_WIDTH   = 12,
	parameter int INTEGRAL_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  cmd_t                    cmd,
	output status_t                 status,
	input  logic [SAMPLE_WIDTH-1:0] sample [SENSOR_MAX],
	output logic [DUTY_W-1:0]       left_duty,
	output logic                    left_reverse,
	output logic [DUTY_W-1:0]       right_duty,
	output logic                    right_reverse,
	output logic signed [ERR_W-1:0] line_error,
	output logic                    line_lost
);

	localparam int IW = INTEGRAL_WIDTH;
	localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW-1){1'b0}}};

	logic [SAMPLE_WIDTH-1:0]   smp_q [SENSOR_MAX];
	logic [THR_EXT_W-1:0]      thr_lo_ext, thr_hi_ext;
	logic signed [SUM_W-1:0]   sum_c;
	logic [CNT_W-1:0]          cnt_c;
	logic [MAG_W-1:0]          mag_c;

	logic [CNT_W-1:0]          cnt_q;
	logic                      neg_q;
	logic                      lost_q;
	logic [CNT_W-1:0]          rem_q, rem_d;
	logic [DIVIDEND_W-1:0]     quo_q, quo_d;

	logic signed [ERR_W-1:0]   quo_s;
	logic signed [ERR_W-1:0]   err_c;
	logic signed [IW:0]        isum_c;
	logic signed [IW-1:0]      integ_c;
	logic signed [DERIV_W-1:0] deriv_c;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [IW-1:0]      integ_q;
	logic signed [DERIV_W-1:0] deriv_q;

	logic signed [OP_W-1:0]    op_c;
	logic signed [CHUNK_W:0]   chunk_c;
	logic signed [GAIN_W-1:0]  gain_c;
	logic signed [PROD_W-1:0]  prod_c;
	logic signed [PROD_W-1:0]  prod_s1;
	logic                      hi_s1;
	logic signed [ACC_W-1:0]   add_c;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [SPEED_W-1:0] base16_c, left_v, right_v;
	wheel_t                    left_w, right_w;

	// Active sensors, weighted sum and count
	assign thr_lo_ext = THR_EXT_W'(cfg.thr_lo);
	assign thr_hi_ext = THR_EXT_W'(cfg.thr_hi);

	always_comb begin
		logic [SAMPLE_WIDTH-1:0] thr;
		sum_c = '0;
		cnt_c = '0;
		for (int i = 0; i < SENSOR_MAX; i++) begin
			thr = (i < 4) ? thr_lo_ext[SAMPLE_WIDTH*(i % 4) +: SAMPLE_WIDTH]
				: thr_hi_ext[SAMPLE_WIDTH*(i % 4) +: SAMPLE_WIDTH];
			if (i < SENSOR_COUNT && smp_q[i] > thr) begin
				sum_c = sum_c + SUM_W'(WEIGHTS[i]);
				cnt_c = cnt_c + 1'b1;
			end
		end
		mag_c = MAG_W'(sum_c[SUM_W-1] ? -sum_c : sum_c);
	end

	assign status.lost = (cnt_c == '0);

	// Restoring divider, two quotient bits per step
	always_comb begin
		logic [CNT_W-1:0] t;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int k = 0; k < DIV_BITS_CYCLE; k++) begin
			t     = {rem_d[CNT_W-2:0], quo_d[DIVIDEND_W-1]};
			quo_d = {quo_d[DIVIDEND_W-2:0], 1'b0};
			if (t >= cnt_q) begin
				t        = t - cnt_q;
				quo_d[0] = 1'b1;
			end
			rem_d = t;
		end
	end

	// Error, derivative and saturating integral
	assign quo_s   = ERR_W'(signed'(quo_q));
	assign err_c   = lost_q ? prev_q : (neg_q ? -quo_s : quo_s);
	assign deriv_c = DERIV_W'(err_c) - DERIV_W'(prev_q);
	assign isum_c  = (IW+1)'(integ_q) + (IW+1)'(err_c);

	always_comb begin
		integ_c = isum_c[IW-1:0];
		if (isum_c[IW] != isum_c[IW-1]) begin
			integ_c = isum_c[IW] ? I_MIN : I_MAX;
		end
	end

	// Multiplier operand and gain select; the high chunk carries the sign
	always_comb begin
		unique case (cmd.term)
			TERM_P: begin
				op_c   = OP_W'(err_q);
				gain_c = cfg.kp;
			end
			TERM_I: begin
				op_c   = OP_W'(integ_q);
				gain_c = cfg.ki;
			end
			default: begin
				op_c   = OP_W'(deriv_q);
				gain_c = cfg.kd;
			end
		endcase
		chunk_c = cmd.hi ? (CHUNK_W+1)'($signed(op_c[OP_W-1:CHUNK_W]))
			: {1'b0, op_c[CHUNK_W-1:0]};
	end

	assign prod_c = gain_c * chunk_c;
	assign add_c  = hi_s1 ? (ACC_W'(prod_s1) <<< CHUNK_W) : ACC_W'(prod_s1);

	// Wheel speeds
	assign base16_c = SPEED_W'({cfg.base, 16'b0});
	assign left_v   = base16_c + SPEED_W'(acc_q);
	assign right_v  = base16_c - SPEED_W'(acc_q);
	assign left_w   = wheel_f(left_v, cfg.rev);
	assign right_w  = wheel_f(right_v, cfg.rev);

	// PID state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else if (cmd.err_upd) begin
			prev_q  <= err_c;
			integ_q <= integ_c;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q <= sample;
		end
		if (cmd.sense) begin
			cnt_q  <= cnt_c;
			neg_q  <= sum_c[SUM_W-1];
			lost_q <= (cnt_c == '0);
			rem_q  <= '0;
			quo_q  <= {mag_c, 8'b0};
		end else if (cmd.div_step) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
		if (cmd.err_upd) begin
			err_q   <= err_c;
			deriv_q <= deriv_c;
		end
		if (cmd.mul) begin
			prod_s1 <= prod_c;
			hi_s1   <= cmd.hi;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + add_c;
		end
		if (cmd.out_load) begin
			left_duty     <= left_w.duty;
			left_reverse  <= left_w.reverse;
			right_duty    <= right_w.duty;
			right_reverse <= right_w.reverse;
			line_error    <= err_q;
			line_lost     <= lost_q;
		end
	end

endmodule

### rtl/core/line_follower_pid_steering_core.sv
// ----------------------------------------------------------------------------
// line_follower_pid_steering_core: PID steering for a line following robot
// One item of eight reflectance samples in, one item of wheel commands out.
//
// Input channel: in_valid/in_stall with sample_0..sample_7. Output channel:
// out_valid/out_stall with both wheel duties and directions, the position
// error and the line-lost flag. Config: cfg_we/cfg_index/cfg_data; the user
// writes it only while the core is idle (not enforced by the core); indexes past the last register are ignored.
//
// Each item goes through sensing, the two-bit-per-cycle divider, the error
// and integral update, six passes of the shared 32x25 multiplier (two chunks
// per PID term), the last accumulate and the wheel mapping. With the line
// lost the divider is skipped. The next item is taken in the cycle after the
// result is loaded; no new item is taken while one is in flight.
//
// Reset clears the error history, the integral and the handshake state and
// loads the default gains and speeds. A stalled result sits in the output
// register; the core keeps working on the next item and holds its finished
// result in the last step until the output register frees up.
// ----------------------------------------------------------------------------
module line_follower_pid_steering_core
	import lfps_pkg::*;
#(
	parameter int SENSOR_COUNT   = 8,
	parameter int SAMPLE_WIDTH   = 12,
	parameter int INTEGRAL_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SAMPLE_WIDTH-1:0] sample_0,
	input  logic [SAMPLE_WIDTH-1:0] sample_1,
	input  logic [SAMPLE_WIDTH-1:0] sample_2,
	input  logic [SAMPLE_WIDTH-1:0] sample_3,
	input  logic [SAMPLE_WIDTH-1:0] sample_4,
	input  logic [SAMPLE_WIDTH-1:0] sample_5,
	input  logic [SAMPLE_WIDTH-1:0] sample_6,
	input  logic [SAMPLE_WIDTH-1:0] sample_7,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DUTY_W-1:0]       left_duty,
	output logic                    left_reverse,
	output logic [DUTY_W-1:0]       right_duty,
	output logic                    right_reverse,
	output logic signed [ERR_W-1:0] line_error,
	output logic                    line_lost
);

	cfg_t                    cfg_q;
	cmd_t                    cmd;
	status_t                 status;
	logic [SAMPLE_WIDTH-1:0] sample [SENSOR_MAX];

	assign sample[0] = sample_0;
	assign sample[1] = sample_1;
	assign sample[2] = sample_2;
	assign sample[3] = sample_3;
	assign sample[4] = sample_4;
	assign sample[5] = sample_5;
	assign sample[6] = sample_6;
	assign sample[7] = sample_7;

	// Config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THR_LO:  cfg_q.thr_lo <= cfg_data;
				REG_THR_HI:  cfg_q.thr_hi <= cfg_data;
				REG_KP:      cfg_q.kp     <= cfg_data[GAIN_W-1:0];
				REG_KI:      cfg_q.ki     <= cfg_data[GAIN_W-1:0];
				REG_KD:      cfg_q.kd     <= cfg_data[GAIN_W-1:0];
				REG_BASE:    cfg_q.base   <= cfg_data[DUTY_W-1:0];
				REG_REVERSE: cfg_q.rev    <= cfg_data[DUTY_W-1:0];
				default:     cfg_q        <= cfg_q;
			endcase
		end
	end

	lfps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lfps_dp #(
		.SENSOR_COUNT   (SENSOR_COUNT),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.status        (status),
		.sample        (sample),
		.left_duty     (left_duty),
		.left_reverse  (left_reverse),
		.right_duty    (right_duty),
		.right_reverse (right_reverse),
		.line_error    (line_error),
		.line_lost     (line_lost)
	);

endmodule

### verif/line_follower_pid_steering_core_tb.sv
// ----------------------------------------------------------------------------
// line_follower_pid_steering_core_tb: self-checking bench for the steering core
// Drives sensor ticks through the valid/stall input channel, predicts the
// wheel commands, position error and line-lost flag of every tick, and
// checks each result in order. A short directed table comes first, then
// random ticks under a series of controller settings with random idling,
// one long output hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module line_follower_pid_steering_core_tb;
	import lfps_pkg::*;

	localparam int      HALF_PERIOD     = 10;
	localparam int      PHASES          = 12;
	localparam int      TICKS_PER_PHASE = 150;
	localparam int      PRESSURE_PHASE  = 5;
	localparam int      HOLD_CYCLES     = 200;
	localparam int      TAIL_CYCLES     = 40;
	localparam int      TIMEOUT_CYCLES  = 500000;
	localparam longint INTEG_MAX       = 64'sd2147483647;
	localparam longint INTEG_MIN       = -64'sd2147483648;
	localparam longint PRODUCT_CAP     = 64'sd1 <<< 61;
	localparam logic [2:0] REG_UNUSED  = 3'd7;

	// Settings with some fixed fields; the rest are fully random
	localparam int PH_NEVER_ON    = 0;
	localparam int PH_GAIN_LIMITS = 1;
	localparam int PH_CREEP       = 2;
	localparam int PH_FULL_BASE   = 3;

	localparam int POS_WEIGHT [8] = '{-4, -3, -3, 1, 1, 2, 3, 4};

	typedef logic [7:0][11:0] tick_t;

	typedef struct packed {
		logic [47:0]        thr_lo;
		logic [47:0]        thr_hi;
		logic signed [31:0] kp;
		logic signed [31:0] ki;
		logic signed [31:0] kd;
		logic [7:0]         base;
		logic [7:0]         rev;
	} steer_cfg_t;

	typedef struct packed {
		logic [7:0]         left_duty;
		logic               left_rev;
		logic [7:0]         right_duty;
		logic               right_rev;
		logic signed [11:0] err;
		logic               lost;
	} steer_t;

	// Directed row: sensors in on_mask read on_level, the others read zero
	typedef struct packed {
		logic [7:0]  on_mask;
		logic [11:0] on_level;
		logic        typed;
		steer_t      want;
	} dir_row_t;

	// Run under reset settings: zero thresholds, Kp 25600, Ki 0, Kd 25600000,
	// base 240, reverse duty 70
	localparam dir_row_t DIR_TABLE [19] = '{
		'{8'h00, 12'd0,    1'b1, '{8'd240, 1'b0, 8'd240, 1'b0, 12'sd0,     1'b1}},
		'{8'hFF, 12'd4095, 1'b1, '{8'd255, 1'b0, 8'd70,  1'b1, 12'sd32,    1'b0}},
		'{8'h01, 12'd1,    1'b1, '{8'd70,  1'b1, 8'd255, 1'b0, -12'sd1024, 1'b0}},
		'{8'h80, 12'd4095, 1'b1, '{8'd255, 1'b0, 8'd70,  1'b1, 12'sd1024,  1'b0}},
		'{8'h00, 12'd0,    1'b1, '{8'd255, 1'b0, 8'd70,  1'b1, 12'sd1024,  1'b1}},
		'{8'h80, 12'd4095, 1'b1, '{8'd255, 1'b0, 8'd70,  1'b1, 12'sd1024,  1'b0}},
		'{8'h18, 12'd2048, 1'b0, '0},
		'{8'h18, 12'd2048, 1'b0, '0},
		'{8'h07, 12'd4095, 1'b0, '0},
		'{8'h09, 12'd100,  1'b0, '0},
		'{8'h06, 12'd3000, 1'b0, '0},
		'{8'h0F, 12'd1,    1'b0, '0},
		'{8'hF0, 12'd2222, 1'b0, '0},
		'{8'h60, 12'd4095, 1'b0, '0},
		'{8'h24, 12'd777,  1'b0, '0},
		'{8'h7F, 12'd4095, 1'b0, '0},
		'{8'hFE, 12'd1234, 1'b0, '0},
		'{8'h00, 12'd0,    1'b0, '0},
		'{8'hFF, 12'd4095, 1'b0, '0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = 3'd0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [11:0]        sample_0 = '0;
	logic [11:0]        sample_1 = '0;
	logic [11:0]        sample_2 = '0;
	logic [11:0]        sample_3 = '0;
	logic [11:0]        sample_4 = '0;
	logic [11:0]        sample_5 = '0;
	logic [11:0]        sample_6 = '0;
	logic [11:0]        sample_7 = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [DUTY_W-1:0]  left_duty;
	logic               left_reverse;
	logic [DUTY_W-1:0]  right_duty;
	logic               right_reverse;
	logic signed [11:0] line_error;
	logic               line_lost;

	// Predictor state and settings
	steer_cfg_t cfg;
	longint     prev_err;
	longint     integ;
	steer_t     pending_cmds [$];

	bit idle_on = 1'b1;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int fail_count = 0;
	int results_seen = 0;
	int lost_seen = 0;
	int reverse_seen = 0;

	line_follower_pid_steering_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_0     (sample_0),
		.sample_1     (sample_1),
		.sample_2     (sample_2),
		.sample_3     (sample_3),
		.sample_4     (sample_4),
		.sample_5     (sample_5),
		.sample_6     (sample_6),
		.sample_7     (sample_7),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_duty    (left_duty),
		.left_reverse (left_reverse),
		.right_duty   (right_duty),
		.right_reverse(right_reverse),
		.line_error   (line_error),
		.line_lost    (line_lost)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [11:0] threshold_of(input int i);
		logic [47:0] bank;
		bank = (i < 4) ? cfg.thr_lo : cfg.thr_hi;
		return bank[12 * (i % 4) +: 12];
	endfunction

	// Gain times operand, capped at +/-2^61
	function automatic longint gain_term(input logic signed [31:0] g, input longint x);
		longint p;
		p = longint'(g) * x;
		if (p > PRODUCT_CAP) p = PRODUCT_CAP;
		if (p < -PRODUCT_CAP) p = -PRODUCT_CAP;
		return p;
	endfunction

	// Q.16 speed to duty and direction, truncating toward zero
	function automatic void wheel_cmd(input longint v, output logic [7:0] duty,
		output logic rev);
		rev = 1'b0;
		if (v >= (64'sd256 <<< 16)) begin
			duty = 8'hFF;
		end else if (v <= -(64'sd1 <<< 16)) begin
			duty = cfg.rev;
			rev  = 1'b1;
		end else if (v < 0) begin
			duty = 8'h00;
		end else begin
			duty = v[23:16];
		end
	endfunction

	// One control tick: error, integral, PID correction, wheel commands
	function automatic steer_t steer_step(input tick_t t);
		steer_t r;
		int     sum;
		int     active;
		longint err;
		longint deriv;
		longint corr;
		longint base_q16;
		sum    = 0;
		active = 0;
		for (int i = 0; i < 8; i++) begin
			if (t[i] > threshold_of(i)) begin
				sum += POS_WEIGHT[i];
				active++;
			end
		end
		r.lost = (active == 0);
		// with no sensor on, hold the last error
		err = r.lost ? prev_err : (longint'(sum) * 256) / active;
		integ = integ + err;
		if (integ > INTEG_MAX) integ = INTEG_MAX;
		if (integ < INTEG_MIN) integ = INTEG_MIN;
		deriv = err - prev_err;
		corr  = gain_term(cfg.kp, err) + gain_term(cfg.ki, integ)
			+ gain_term(cfg.kd, deriv);
		prev_err = err;
		base_q16 = longint'(cfg.base) <<< 16;
		wheel_cmd(base_q16 + corr, r.left_duty, r.left_rev);
		wheel_cmd(base_q16 - corr, r.right_duty, r.right_rev);
		r.err = err[11:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [11:0] over(input logic [11:0] thr);
		if (thr == 12'hFFF) return thr;
		return 12'($urandom_range(32'(thr) + 1, 4095));
	endfunction

	function automatic logic [11:0] not_over(input logic [11:0] thr);
		return 12'($urandom_range(0, 32'(thr)));
	endfunction

	// Mostly a line under a few adjacent sensors; some noise, no-line and
	// at-threshold ticks
	function automatic tick_t make_tick();
		tick_t       t;
		int          kind;
		int          first;
		int          span;
		logic [11:0] thr;
		kind  = $urandom_range(0, 9);
		first = $urandom_range(0, 7);
		span  = $urandom_range(1, 3);
		for (int i = 0; i < 8; i++) begin
			thr = threshold_of(i);
			if (kind < 2) begin
				t[i] = 12'($urandom);
			end else if (kind < 8) begin
				t[i] = (i >= first && i < first + span) ? over(thr) : not_over(thr);
			end else if (kind == 8) begin
				t[i] = ($urandom_range(0, 3) == 0) ? thr : not_over(thr);
			end else begin
				case ($urandom_range(0, 2))
					0: t[i] = over(thr);
					1: t[i] = thr;
					default: t[i] = not_over(thr);
				endcase
			end
		end
		return t;
	endfunction

	function automatic logic signed [31:0] rand_gain();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	function automatic steer_cfg_t pick_settings(input int ph);
		steer_cfg_t s;
		s.thr_lo = 48'({$urandom, $urandom});
		s.thr_hi = 48'({$urandom, $urandom});
		s.kp     = rand_gain();
		s.ki     = rand_gain();
		s.kd     = rand_gain();
		s.base   = 8'($urandom);
		s.rev    = 8'($urandom);
		case (ph)
			PH_NEVER_ON: begin
				s.thr_lo = '1;
				s.thr_hi = '1;
				s.kp     = 32'sh7FFFFFFF;
				s.ki     = 32'sh80000000;
				s.kd     = '0;
				s.base   = 8'd255;
				s.rev    = 8'd255;
			end
			PH_GAIN_LIMITS: begin
				s.thr_lo = '0;
				s.thr_hi = '0;
				s.kp     = 32'sh80000000;
				s.ki     = 32'sh7FFFFFFF;
				s.kd     = 32'sh80000000;
				s.base   = 8'd0;
				s.rev    = 8'd0;
			end
			PH_CREEP: begin
				// tiny gains around zero base: speeds just above and below zero
				s.kp   = 32'sd1;
				s.ki   = 32'sd0;
				s.kd   = 32'sd1;
				s.base = 8'd0;
				s.rev  = 8'd255;
			end
			PH_FULL_BASE: begin
				s.base = 8'd255;
				s.rev  = 8'd0;
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_THR_LO:  cfg.thr_lo = data;
			REG_THR_HI:  cfg.thr_hi = data;
			REG_KP:      cfg.kp     = data[31:0];
			REG_KI:      cfg.ki     = data[31:0];
			REG_KD:      cfg.kd     = data[31:0];
			REG_BASE:    cfg.base   = data[7:0];
			REG_REVERSE: cfg.rev    = data[7:0];
			default: begin
			end
		endcase
	endtask

	// Upper bits of narrow registers carry junk that must be dropped
	task automatic program_core(input steer_cfg_t s);
		write_reg(REG_THR_LO, s.thr_lo);
		write_reg(REG_THR_HI, s.thr_hi);
		write_reg(REG_KP, {16'($urandom), s.kp});
		write_reg(REG_KI, {16'($urandom), s.ki});
		write_reg(REG_KD, {16'($urandom), s.kd});
		write_reg(REG_BASE, {40'($urandom), s.base});
		write_reg(REG_REVERSE, {40'($urandom), s.rev});
		write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
		cfg_we <= 1'b0;
	endtask

	// Offer one tick; predict once it is accepted
	task automatic offer_tick(input tick_t t, input bit typed, input steer_t want);
		steer_t predicted;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_0 <= t[0];
		sample_1 <= t[1];
		sample_2 <= t[2];
		sample_3 <= t[3];
		sample_4 <= t[4];
		sample_5 <= t[5];
		sample_6 <= t[6];
		sample_7 <= t[7];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = steer_step(t);
		pending_cmds.push_back(typed ? want : predicted);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: checking and stall generation
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_cmd();
		steer_t want;
		if (pending_cmds.size() == 0) begin
			$error("steering result with no tick outstanding");
			fail_count++;
		end else begin
			want = pending_cmds.pop_front();
			results_seen++;
			if (want.lost) lost_seen++;
			if (want.left_rev || want.right_rev) reverse_seen++;
			check_field("left_duty", want.left_duty, left_duty);
			check_field("left_reverse", want.left_rev, left_reverse);
			check_field("right_duty", want.right_duty, right_duty);
			check_field("right_reverse", want.right_rev, right_reverse);
			check_field("line_error", longint'(want.err), longint'(line_error));
			check_field("line_lost", want.lost, line_lost);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) check_cmd();
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		// long hold-off first, then short random bursts
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		tick_t t;
		cfg      = '{thr_lo: '0, thr_hi: '0, kp: 32'sd25600, ki: 32'sd0,
			kd: 32'sd25600000, base: 8'd240, rev: 8'd70};
		prev_err = 0;
		integ    = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < $size(DIR_TABLE); r++) begin
			for (int i = 0; i < 8; i++)
				t[i] = DIR_TABLE[r].on_mask[i] ? DIR_TABLE[r].on_level : 12'd0;
			offer_tick(t, DIR_TABLE[r].typed, DIR_TABLE[r].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			program_core(pick_settings(ph));
			// last phase runs at full rate on both sides
			idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (ph == PRESSURE_PHASE) hold_request = 1'b1;
			repeat (TICKS_PER_PHASE) offer_tick(make_tick(), 1'b0, '0);
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d steering results across %0d controller settings plus reset",
			results_seen, PHASES);
		$display("  %0d with the line lost, %0d with a wheel driven in reverse",
			lost_seen, reverse_seen);
		if (fail_count == 0 && pending_cmds.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#(2 * HALF_PERIOD * TIMEOUT_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

endmodule
